/* rtl/assert_macros.svh */
// assertion macros shared by the sampler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression holds at every clock edge outside reset
`define TNSG_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("tnsg assertion failed");
// antecedent at one edge implies consequent at the next
`define TNSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tnsg assertion failed");
`else
`define TNSG_ASSERT_ALWAYS(label, clk, rst, expr)
`define TNSG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/tnsg_pkg.sv */
// shared types and constants of the nearest texture sampler
`default_nettype none
package tnsg_pkg;

   // field widths
   localparam int COORD_W    = 24;
   localparam int FRAC_W     = 16;
   localparam int FIX_W      = 24;
   localparam int WADDR_W    = 18;
   localparam int BYTE_W     = 8;
   localparam int CHAN_W     = 25;
   localparam int NUM_CHAN   = 3;

   // configuration register widths
   localparam int CFG_SIDE_W = 11;
   localparam int CFG_CH_W   = 3;
   localparam int CFG_REP_W  = 16;
   localparam int CFG_GAIN_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   // byte banks of the texture store
   localparam int NUM_BANKS  = 4;
   localparam int BANK_SEL_W = 2;

   // divide by 255 by reciprocal: 65793 / 2^24 is just under 1/255
   localparam int DIV_C      = 255;
   localparam int RECIP_C    = 65793;
   localparam int RECIP_W    = 17;
   localparam int RECIP_SH   = 24;
   localparam int DIV_SQ     = 65025;

   // opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_WRITE  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_U      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_V      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN          = 3'd5;

   typedef struct packed {
      logic [CFG_SIDE_W-1:0] tex_width;
      logic [CFG_SIDE_W-1:0] tex_height;
      logic [CFG_CH_W-1:0]   channel_count;
      logic [CFG_REP_W-1:0]  repeat_u;
      logic [CFG_REP_W-1:0]  repeat_v;
      logic [CFG_GAIN_W-1:0] gain;
   } csr_type;

   localparam csr_type CSR_RESET = '{
      tex_width:     11'd256,
      tex_height:    11'd256,
      channel_count: 3'd3,
      repeat_u:      16'd256,
      repeat_v:      16'd256,
      gain:          16'd4096
   };

   typedef struct packed {
      logic               en;
      logic [WADDR_W-1:0] addr;
      logic [BYTE_W-1:0]  data;
   } mem_wr_type;

endpackage
`default_nettype wire

/* rtl/tnsg_req_if.sv */
// request channel: sample and texture byte write beats
`default_nettype none
interface tnsg_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   opcode;
   logic signed [tnsg_pkg::COORD_W-1:0]    coord_u;
   logic signed [tnsg_pkg::COORD_W-1:0]    coord_v;
   logic        [tnsg_pkg::WADDR_W-1:0]    write_addr;
   logic        [tnsg_pkg::BYTE_W-1:0]     write_byte;

   modport source (output valid, opcode, coord_u, coord_v, write_addr, write_byte,
                   input ready);
   modport sink   (input valid, opcode, coord_u, coord_v, write_addr, write_byte,
                   output ready);
endinterface
`default_nettype wire

/* rtl/tnsg_rsp_if.sv */
// response channel: shaded colour beats
`default_nettype none
interface tnsg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tnsg_pkg::CHAN_W-1:0]   red;
   logic [tnsg_pkg::CHAN_W-1:0]   green;
   logic [tnsg_pkg::CHAN_W-1:0]   blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

/* rtl/tnsg_coord.sv */
// coordinate pipeline: wrap, repeat, texel index and byte address
`default_nettype none
module tnsg_coord #(
   parameter int unsigned MAX_SIDE = 1024,
   parameter int          SIDE_W   = 11,
   parameter int          ADDR_W   = 18
) (
   input  logic                                   clock,
   input  logic                                   adv,
   input  tnsg_pkg::csr_type                      csr,
   input  logic signed [tnsg_pkg::COORD_W-1:0]    coord_u,
   input  logic signed [tnsg_pkg::COORD_W-1:0]    coord_v,
   input  logic        [tnsg_pkg::WADDR_W-1:0]    write_addr,
   input  logic        [tnsg_pkg::BYTE_W-1:0]     write_byte,
   output logic        [ADDR_W-1:0]               base,
   output logic        [tnsg_pkg::WADDR_W-1:0]    wr_addr,
   output logic        [tnsg_pkg::BYTE_W-1:0]     wr_byte
);

   localparam int FRAC_W = tnsg_pkg::FRAC_W;
   localparam int FIX_W  = tnsg_pkg::FIX_W;
   localparam int RED_W  = FRAC_W + 1;
   localparam int PRU_W  = RED_W + tnsg_pkg::CFG_REP_W;
   localparam int MU_W   = FIX_W + SIDE_W;
   localparam int MV_W   = FIX_W + 1 + SIDE_W;
   localparam int LIN_W  = 2 * SIDE_W;
   localparam int BP_W   = LIN_W + tnsg_pkg::CFG_CH_W;
   localparam int NCARRY = 4;
   localparam logic [RED_W-1:0] RED_ONE = RED_W'(1) << FRAC_W;
   localparam logic [FIX_W:0]   FIX_ONE = (FIX_W + 1)'(1) << FIX_W;

   // wrap a Q8.16 coordinate into [0,1] as Q1.16
   function automatic logic [RED_W-1:0] reduce_coord(input logic [tnsg_pkg::COORD_W-1:0] c);
      logic [FRAC_W-1:0] frac;
      frac = c[FRAC_W-1:0];
      if (frac != '0) return RED_W'(frac);
      if (!c[tnsg_pkg::COORD_W-1] && (c != '0)) return RED_ONE;
      return '0;
   endfunction

   // clamp a texel index to the side, zero side gives index zero
   function automatic logic [SIDE_W-1:0] clamp_index(input logic [SIDE_W-1:0] k,
                                                     input logic [SIDE_W-1:0] side);
      if (side == '0) return '0;
      if (k >= side) return side - SIDE_W'(1);
      return k;
   endfunction

   logic [SIDE_W-1:0] side_w;
   logic [SIDE_W-1:0] side_h;

   // sides limited to the largest supported texture
   assign side_w = (32'(csr.tex_width) > MAX_SIDE) ? SIDE_W'(MAX_SIDE)
                                                   : SIDE_W'(csr.tex_width);
   assign side_h = (32'(csr.tex_height) > MAX_SIDE) ? SIDE_W'(MAX_SIDE)
                                                    : SIDE_W'(csr.tex_height);

   // stage 1: wrap and repeat, keep the fraction
   logic [PRU_W-1:0] pru;
   logic [PRU_W-1:0] prv;
   logic [FIX_W-1:0] fu_ff;
   logic [FIX_W-1:0] fv_ff;

   assign pru = PRU_W'(reduce_coord(coord_u)) * PRU_W'(csr.repeat_u);
   assign prv = PRU_W'(reduce_coord(coord_v)) * PRU_W'(csr.repeat_v);

   // stage 2: scale by the sides
   logic [MU_W-1:0]   mu;
   logic [MV_W-1:0]   mv;
   logic [FIX_W:0]    fv_flip;
   logic [SIDE_W-1:0] ku_ff;
   logic [SIDE_W-1:0] kv_ff;

   assign fv_flip = FIX_ONE - {1'b0, fv_ff};
   assign mu      = MU_W'(fu_ff) * MU_W'(side_w);
   assign mv      = MV_W'(fv_flip) * MV_W'(side_h);

   // stage 3: clamp and form the texel number
   logic [SIDE_W-1:0] ti;
   logic [SIDE_W-1:0] tj;
   logic [LIN_W-1:0]  lin_in;
   logic [LIN_W-1:0]  lin_ff;

   assign ti     = clamp_index(ku_ff, side_w);
   assign tj     = clamp_index(kv_ff, side_h);
   assign lin_in = LIN_W'(ti) + LIN_W'(side_w) * LIN_W'(tj);

   // stage 4: byte address, wrapped to the store size
   logic [BP_W-1:0]   bp;
   logic [ADDR_W-1:0] base_ff;

   assign bp = BP_W'(csr.channel_count) * BP_W'(lin_ff);

   // write beats ride alongside the address stages
   logic [tnsg_pkg::WADDR_W-1:0] waddr_ff [NCARRY];
   logic [tnsg_pkg::BYTE_W-1:0]  wbyte_ff [NCARRY];

   always_ff @(posedge clock) begin
      if (adv) begin
         fu_ff   <= pru[FIX_W-1:0];
         fv_ff   <= prv[FIX_W-1:0];
         ku_ff   <= mu[FIX_W +: SIDE_W];
         kv_ff   <= mv[FIX_W +: SIDE_W];
         lin_ff  <= lin_in;
         base_ff <= ADDR_W'(bp);
         waddr_ff[0] <= write_addr;
         wbyte_ff[0] <= write_byte;
         for (int k = 1; k < NCARRY; k++) begin
            waddr_ff[k] <= waddr_ff[k-1];
            wbyte_ff[k] <= wbyte_ff[k-1];
         end
      end
   end

   assign base    = base_ff;
   assign wr_addr = waddr_ff[NCARRY-1];
   assign wr_byte = wbyte_ff[NCARRY-1];

endmodule
`default_nettype wire

/* rtl/tnsg_store.sv */
// texture store: four byte banks, three channel bytes read per beat
`default_nettype none
module tnsg_store #(
   parameter int ADDR_W = 18
) (
   input  logic                                              clock,
   input  logic                                              adv,
   input  tnsg_pkg::mem_wr_type                              wr,
   input  logic [ADDR_W-1:0]                                 base,
   output logic [tnsg_pkg::NUM_CHAN-1:0][tnsg_pkg::BYTE_W-1:0] chan_byte
);

   localparam int SEL_W = tnsg_pkg::BANK_SEL_W;
   localparam int ROW_W = ADDR_W - SEL_W;
   localparam int DEPTH = 2 ** ROW_W;

   logic [ADDR_W-1:0]                                         waddr;
   logic [tnsg_pkg::NUM_BANKS-1:0][tnsg_pkg::BYTE_W-1:0]      rd_bank;
   logic [SEL_W-1:0]                                          lane_ff;

   assign waddr = ADDR_W'(wr.addr);

   // bank holding the first channel byte
   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= base[SEL_W-1:0];
      end
   end

   for (genvar b = 0; b < tnsg_pkg::NUM_BANKS; b++) begin : g_bank
      logic [tnsg_pkg::BYTE_W-1:0] mem [DEPTH];
      logic [tnsg_pkg::BYTE_W-1:0] rd_ff;
      logic [SEL_W-1:0]            lane_off;
      logic [ADDR_W-1:0]           rsum;

      // byte of this bank among base, base+1, base+2
      assign lane_off = SEL_W'(b) - base[SEL_W-1:0];
      assign rsum     = base + ADDR_W'(lane_off);

      always_ff @(posedge clock) begin
         if (adv && wr.en && (waddr[SEL_W-1:0] == SEL_W'(b))) begin
            mem[waddr[ADDR_W-1:SEL_W]] <= wr.data;
         end
         if (adv) begin
            rd_ff <= mem[rsum[ADDR_W-1:SEL_W]];
         end
      end

      assign rd_bank[b] = rd_ff;
   end

   // steer banks back into channel order
   always_comb begin
      logic [SEL_W-1:0] sel;
      for (int o = 0; o < tnsg_pkg::NUM_CHAN; o++) begin
         sel = lane_ff + SEL_W'(o);
         chan_byte[o] = rd_bank[sel];
      end
   end

endmodule
`default_nettype wire

/* rtl/tnsg_shade.sv */
// channel shading pipeline: scale by gain/255, square, truncate to Q9.16
`default_nettype none
module tnsg_shade (
   input  logic                               clock,
   input  logic                               adv,
   input  logic [tnsg_pkg::CFG_GAIN_W-1:0]    gain,
   input  logic [tnsg_pkg::BYTE_W-1:0]        byte_in,
   output logic [tnsg_pkg::CHAN_W-1:0]        chan
);

   localparam int BW    = tnsg_pkg::BYTE_W;
   localparam int S_W   = BW + tnsg_pkg::CFG_GAIN_W;
   localparam int A_W   = tnsg_pkg::CFG_GAIN_W;
   localparam int PA_W  = S_W + tnsg_pkg::RECIP_W;
   localparam int M_W   = A_W + BW + 1;
   localparam int PM_W  = M_W + tnsg_pkg::RECIP_W;
   localparam int P_W   = M_W - BW;
   localparam int A2_W  = 2 * A_W;
   localparam int SQ_W  = 2 * BW;
   localparam int T_W   = SQ_W + 1;
   localparam int SUM_W = A2_W + 1;
   localparam int SH    = tnsg_pkg::RECIP_SH;
   localparam logic [S_W-1:0]  DIV_S  = S_W'(tnsg_pkg::DIV_C);
   localparam logic [M_W-1:0]  DIV_M  = M_W'(tnsg_pkg::DIV_C);
   localparam logic [T_W-1:0]  DIV_T  = T_W'(tnsg_pkg::DIV_C);
   localparam logic [T_W-1:0]  SQ_LIM = T_W'(tnsg_pkg::DIV_SQ);

   // scaled value s = byte*gain = 255*a + b, s^2 = 65025*(a^2 + p) + 255*q1 + b^2
   // with 2*a*b = 255*p + q1; the tail is below 2*65025 so one compare closes it

   // e1: scaled value
   logic [S_W-1:0] s_ff;

   // e2: first quotient estimate of s/255
   logic [PA_W-1:0] pa;
   logic [A_W-1:0]  a0_ff;
   logic [S_W-1:0]  s2_ff;

   assign pa = PA_W'(s_ff) * PA_W'(tnsg_pkg::RECIP_C);

   // e3: corrected quotient and remainder
   logic [S_W-1:0] rem_a;
   logic [A_W-1:0] a_in;
   logic [BW-1:0]  b_in;
   logic [A_W-1:0] a_ff;
   logic [BW-1:0]  b_ff;

   assign rem_a = s2_ff - S_W'(a0_ff) * DIV_S;

   always_comb begin
      if (rem_a >= DIV_S) begin
         a_in = a0_ff + A_W'(1);
         b_in = BW'(rem_a - DIV_S);
      end else begin
         a_in = a0_ff;
         b_in = BW'(rem_a);
      end
   end

   // e4: cross term and square of the quotient
   logic [M_W-1:0]  m_in;
   logic [M_W-1:0]  m_ff;
   logic [A2_W-1:0] a2_ff;
   logic [BW-1:0]   b4_ff;

   assign m_in = (M_W'(a_ff) * M_W'(b_ff)) << 1;

   // e5: quotient estimate of the cross term, square of the remainder
   logic [PM_W-1:0] pm;
   logic [P_W-1:0]  p0_ff;
   logic [M_W-1:0]  m5_ff;
   logic [A2_W-1:0] a2_5_ff;
   logic [SQ_W-1:0] bsq_ff;

   assign pm = PM_W'(m_ff) * PM_W'(tnsg_pkg::RECIP_C);

   // e6: corrected cross term quotient
   logic [M_W-1:0]  rem_m;
   logic [P_W-1:0]  p_in;
   logic [BW-1:0]   q1_in;
   logic [P_W-1:0]  p_ff;
   logic [BW-1:0]   q1_ff;
   logic [A2_W-1:0] a2_6_ff;
   logic [SQ_W-1:0] bsq6_ff;

   assign rem_m = m5_ff - M_W'(p0_ff) * DIV_M;

   always_comb begin
      if (rem_m >= DIV_M) begin
         p_in  = p0_ff + P_W'(1);
         q1_in = BW'(rem_m - DIV_M);
      end else begin
         p_in  = p0_ff;
         q1_in = BW'(rem_m);
      end
   end

   // e7: final carry from the tail, drop the low byte
   logic [T_W-1:0]    tail;
   logic              corr;
   logic [SUM_W-1:0]  sum;
   logic [tnsg_pkg::CHAN_W-1:0] chan_ff;

   assign tail = T_W'(q1_ff) * DIV_T + T_W'(bsq6_ff);
   assign corr = (tail >= SQ_LIM);
   assign sum  = SUM_W'(a2_6_ff) + SUM_W'(p_ff) + SUM_W'(corr);

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff    <= S_W'(byte_in) * S_W'(gain);
         a0_ff   <= pa[SH +: A_W];
         s2_ff   <= s_ff;
         a_ff    <= a_in;
         b_ff    <= b_in;
         m_ff    <= m_in;
         a2_ff   <= A2_W'(a_ff) * A2_W'(a_ff);
         b4_ff   <= b_ff;
         p0_ff   <= pm[SH +: P_W];
         m5_ff   <= m_ff;
         a2_5_ff <= a2_ff;
         bsq_ff  <= SQ_W'(b4_ff) * SQ_W'(b4_ff);
         p_ff    <= p_in;
         q1_ff   <= q1_in;
         a2_6_ff <= a2_5_ff;
         bsq6_ff <= bsq_ff;
         chan_ff <= sum[SUM_W-1 -: tnsg_pkg::CHAN_W];
      end
   end

   assign chan = chan_ff;

endmodule
`default_nettype wire

/* rtl/texture_nearest_sampler_gamma_unit.sv */
// top level of the nearest texture sampler with repeat and gamma squaring
`default_nettype none
`include "assert_macros.svh"
// Nearest-neighbour texture sampler. Write beats (opcode write) load one byte of the
// texture store; sample beats (opcode sample) take u,v in signed Q8.16, wrap and repeat
// them, pick the nearest texel and return red, green and blue, each scaled by gain/255
// and squared, as unsigned Q9.16. Fully pipelined: one beat enters every cycle unless
// the output stalls, and a sample's result passes 4 address stages, one store read and
// 7 shading stages; write beats give no result. The store is STORE_BYTES bytes
// (a power of two) split into four byte-wide banks, so the three channel bytes of a
// texel are read in the same cycle. The store is not cleared at reset: a texel byte
// must be written before it is sampled. The whole pipeline holds while a result waits
// to be taken. Configuration is written through csr_we/csr_index/csr_wdata while no
// beat is in flight.
module texture_nearest_sampler_gamma_unit #(
   parameter int unsigned STORE_BYTES = 262144,
   parameter int unsigned MAX_SIDE    = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   tnsg_req_if.sink                          req_bus,
   tnsg_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [tnsg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tnsg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int ADDR_W    = $clog2(STORE_BYTES);
   localparam int SIDE_FULL = $clog2(MAX_SIDE + 1);
   localparam int SIDE_W    = (SIDE_FULL < tnsg_pkg::CFG_SIDE_W) ? SIDE_FULL
                                                                 : tnsg_pkg::CFG_SIDE_W;
   localparam int COORD_STG = 4;
   localparam int SHADE_STG = 7;
   localparam int NSTG      = COORD_STG + 1 + SHADE_STG;

   // configuration registers
   tnsg_pkg::csr_type csr_ff;
   tnsg_pkg::csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            tnsg_pkg::CSR_TEX_WIDTH: begin
               csr_in.tex_width = csr_wdata[tnsg_pkg::CFG_SIDE_W-1:0];
            end
            tnsg_pkg::CSR_TEX_HEIGHT: begin
               csr_in.tex_height = csr_wdata[tnsg_pkg::CFG_SIDE_W-1:0];
            end
            tnsg_pkg::CSR_CHANNEL_COUNT: begin
               csr_in.channel_count = csr_wdata[tnsg_pkg::CFG_CH_W-1:0];
            end
            tnsg_pkg::CSR_REPEAT_U: begin
               csr_in.repeat_u = csr_wdata[tnsg_pkg::CFG_REP_W-1:0];
            end
            tnsg_pkg::CSR_REPEAT_V: begin
               csr_in.repeat_v = csr_wdata[tnsg_pkg::CFG_REP_W-1:0];
            end
            tnsg_pkg::CSR_GAIN: begin
               csr_in.gain = csr_wdata[tnsg_pkg::CFG_GAIN_W-1:0];
            end
            default: begin
               csr_in = csr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= tnsg_pkg::CSR_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // pipeline advance: everything moves unless a result is held at the output
   logic adv;
   logic accept;
   logic [NSTG-1:0]      smp_vld_ff;
   logic [NSTG-1:0]      smp_vld_in;
   logic [COORD_STG-1:0] wr_vld_ff;
   logic [COORD_STG-1:0] wr_vld_in;

   assign adv           = !smp_vld_ff[NSTG-1] || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign accept        = req_bus.valid && adv;

   assign smp_vld_in = {smp_vld_ff[NSTG-2:0],
                        accept && (req_bus.opcode == tnsg_pkg::OP_SAMPLE)};
   assign wr_vld_in  = {wr_vld_ff[COORD_STG-2:0],
                        accept && (req_bus.opcode == tnsg_pkg::OP_WRITE)};

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_vld_ff <= '0;
         wr_vld_ff  <= '0;
      end else if (adv) begin
         smp_vld_ff <= smp_vld_in;
         wr_vld_ff  <= wr_vld_in;
      end
   end

   // address stages
   logic [ADDR_W-1:0]             base;
   logic [tnsg_pkg::WADDR_W-1:0]  wr_addr;
   logic [tnsg_pkg::BYTE_W-1:0]   wr_byte;
   tnsg_pkg::mem_wr_type          mem_wr;

   tnsg_coord #(
      .MAX_SIDE (MAX_SIDE),
      .SIDE_W   (SIDE_W),
      .ADDR_W   (ADDR_W)
   ) u_coord (
      .clock      (clock),
      .adv        (adv),
      .csr        (csr_ff),
      .coord_u    (req_bus.coord_u),
      .coord_v    (req_bus.coord_v),
      .write_addr (req_bus.write_addr),
      .write_byte (req_bus.write_byte),
      .base       (base),
      .wr_addr    (wr_addr),
      .wr_byte    (wr_byte)
   );

   // store writes happen at the read stage so beats stay in order
   assign mem_wr.en   = wr_vld_ff[COORD_STG-1];
   assign mem_wr.addr = wr_addr;
   assign mem_wr.data = wr_byte;

   logic [tnsg_pkg::NUM_CHAN-1:0][tnsg_pkg::BYTE_W-1:0] chan_byte;

   tnsg_store #(
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .adv       (adv),
      .wr        (mem_wr),
      .base      (base),
      .chan_byte (chan_byte)
   );

   // one shading pipeline per channel
   logic [tnsg_pkg::NUM_CHAN-1:0][tnsg_pkg::CHAN_W-1:0] chan_val;

   for (genvar c = 0; c < tnsg_pkg::NUM_CHAN; c++) begin : g_shade
      tnsg_shade u_shade (
         .clock   (clock),
         .adv     (adv),
         .gain    (csr_ff.gain),
         .byte_in (chan_byte[c]),
         .chan    (chan_val[c])
      );
   end

   assign rsp_bus.valid = smp_vld_ff[NSTG-1];
   assign rsp_bus.red   = chan_val[0];
   assign rsp_bus.green = chan_val[1];
   assign rsp_bus.blue  = chan_val[2];

   // checks
   `TNSG_ASSERT_NEXT(a_accept_enters, clock, reset, accept, smp_vld_ff[0] || wr_vld_ff[0])
   `TNSG_ASSERT_NEXT(a_stall_holds, clock, reset, !adv, $stable(smp_vld_ff) && $stable(wr_vld_ff))
   `TNSG_ASSERT_NEXT(a_write_bubble, clock, reset, adv && wr_vld_ff[COORD_STG-1], !smp_vld_ff[COORD_STG])
   `TNSG_ASSERT_ALWAYS(a_kind_excl, clock, reset, !(smp_vld_ff[COORD_STG-1] && wr_vld_ff[COORD_STG-1]))

endmodule
`default_nettype wire

/* bench/tnsg_checker.sv */
// colour beat predictor and scoreboard for the nearest texture sampler
`timescale 1ns / 1ps
module tnsg_checker
   import tnsg_pkg::*;
#(
   parameter int unsigned STORE_BYTES = 262144,
   parameter int unsigned MAX_SIDE    = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   tnsg_req_if                   req_bus,
   tnsg_rsp_if                   rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           mismatch_count,
   output int unsigned           pending_results
);

   // (byte*gain/4096/255)^2 in q9.16 reduces to (byte*gain)^2 / (255*255*256)
   localparam longint unsigned SHADE_DIV = 64'd16646400;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } colour_type;

   csr_type          cfg;
   logic [BYTE_W-1:0] texel_bytes [STORE_BYTES];
   colour_type       expected_colours [$];

   // fold a signed q8.16 coordinate into [0,1] as q1.16
   function automatic logic [FRAC_W:0] unit_coord(logic [COORD_W-1:0] raw);
      if (raw[FRAC_W-1:0] != '0) begin
         return {1'b0, raw[FRAC_W-1:0]};
      end
      return (!raw[COORD_W-1] && raw != '0) ? 17'h10000 : 17'h00000;
   endfunction

   // fractional part of coordinate times repeat, q0.24
   function automatic logic [FIX_W-1:0] repeat_wrap(logic [FRAC_W:0] c, logic [CFG_REP_W-1:0] rep);
      logic [32:0] prod;
      prod = c * rep;
      return prod[FIX_W-1:0];
   endfunction

   // floor(f * side), clamped to the last texel
   function automatic logic [CFG_SIDE_W-1:0] nearest_index(logic [FIX_W:0] f,
                                                          logic [CFG_SIDE_W-1:0] side);
      logic [35:0] prod;
      logic [11:0] k;
      logic [11:0] last;
      if (side == '0) begin
         return '0;
      end
      prod = f * side;
      k    = prod[35:24];
      last = 12'(side) - 12'd1;
      if (k > last) begin
         k = last;
      end
      return k[CFG_SIDE_W-1:0];
   endfunction

   // byte address of the texel that a sample lands on
   function automatic int unsigned texel_base(csr_type c, logic [COORD_W-1:0] u,
                                              logic [COORD_W-1:0] v);
      logic [CFG_SIDE_W-1:0] w, h, i, j;
      logic [FIX_W-1:0]      fu, fv;
      w  = (c.tex_width > MAX_SIDE) ? CFG_SIDE_W'(MAX_SIDE) : c.tex_width;
      h  = (c.tex_height > MAX_SIDE) ? CFG_SIDE_W'(MAX_SIDE) : c.tex_height;
      fu = repeat_wrap(unit_coord(u), c.repeat_u);
      fv = repeat_wrap(unit_coord(v), c.repeat_v);
      i  = nearest_index({1'b0, fu}, w);
      j  = nearest_index(25'h1000000 - {1'b0, fv}, h);
      return (c.channel_count * (i + w * j)) % STORE_BYTES;
   endfunction

   // scale by gain/255 and square, truncated to q9.16
   function automatic logic [CHAN_W-1:0] shade(logic [BYTE_W-1:0] texel,
                                               logic [CFG_GAIN_W-1:0] g);
      longint unsigned scaled;
      scaled = 64'(texel) * 64'(g);
      scaled = (scaled * scaled) / SHADE_DIV;
      return scaled[CHAN_W-1:0];
   endfunction

   function automatic colour_type sample_colour(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
      int unsigned base;
      colour_type  c;
      base    = texel_base(cfg, u, v);
      c.red   = shade(texel_bytes[base % STORE_BYTES], cfg.gain);
      c.green = shade(texel_bytes[(base + 1) % STORE_BYTES], cfg.gain);
      c.blue  = shade(texel_bytes[(base + 2) % STORE_BYTES], cfg.gain);
      return c;
   endfunction

   // watch registers, requests and colour beats
   always @(posedge clock) begin
      colour_type want;
      colour_type got;
      if (reset) begin
         cfg = CSR_RESET;
         expected_colours.delete();
         mismatch_count = 0;
      end else begin
         // register writes, unknown indexes fall through
         if (csr_we) begin
            case (csr_index)
               CSR_TEX_WIDTH:     cfg.tex_width     = csr_wdata[CFG_SIDE_W-1:0];
               CSR_TEX_HEIGHT:    cfg.tex_height    = csr_wdata[CFG_SIDE_W-1:0];
               CSR_CHANNEL_COUNT: cfg.channel_count = csr_wdata[CFG_CH_W-1:0];
               CSR_REPEAT_U:      cfg.repeat_u      = csr_wdata[CFG_REP_W-1:0];
               CSR_REPEAT_V:      cfg.repeat_v      = csr_wdata[CFG_REP_W-1:0];
               CSR_GAIN:          cfg.gain          = csr_wdata[CFG_GAIN_W-1:0];
               default: ;
            endcase
         end

         // request beat: store a byte or predict a colour
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.opcode == OP_WRITE) begin
               texel_bytes[req_bus.write_addr % STORE_BYTES] = req_bus.write_byte;
            end else begin
               expected_colours.push_back(sample_colour(req_bus.coord_u, req_bus.coord_v));
            end
         end

         // colour beat against the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.red, rsp_bus.green, rsp_bus.blue};
            if (expected_colours.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected colour beat: red %0d green %0d blue %0d",
                        $time, got.red, got.green, got.blue);
            end else begin
               want = expected_colours.pop_front();
               if (got.red !== want.red || got.green !== want.green
                   || got.blue !== want.blue) begin
                  mismatch_count++;
                  $display("%0t colour mismatch: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                           $time, want.red, want.green, want.blue,
                           got.red, got.green, got.blue);
               end
            end
         end
      end
      pending_results <= expected_colours.size();
   end

endmodule

/* bench/tb.sv */
// stimulus and verdict for the nearest texture sampler
`timescale 1ns / 1ps
module tb;
   import tnsg_pkg::*;

   localparam int unsigned STORE_BYTES     = 262144;
   localparam int unsigned MAX_SIDE        = 1024;
   localparam int unsigned RESET_CYCLES    = 10;
   localparam int unsigned PHASES          = 8;
   localparam int unsigned ITEMS_PER_PHASE = 120;
   localparam int unsigned HOLD_PHASE      = 4;
   localparam int unsigned HOLD_CYCLES     = 300;
   localparam int unsigned SETTLE_CYCLES   = 24;
   localparam int unsigned CYCLE_LIMIT     = 500000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int unsigned           chk_mismatches;
   int unsigned           chk_pending;

   tnsg_req_if req_bus ();
   tnsg_rsp_if rsp_bus ();

   // stimulus side view of the block
   csr_type     cfg;
   bit          texel_written [STORE_BYTES];
   int unsigned items_sent = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_asks = 0;

   texture_nearest_sampler_gamma_unit #(
      .STORE_BYTES(STORE_BYTES),
      .MAX_SIDE   (MAX_SIDE)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   tnsg_checker #(
      .STORE_BYTES(STORE_BYTES),
      .MAX_SIDE   (MAX_SIDE)
   ) chk (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (chk_mismatches),
      .pending_results(chk_pending)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // colour beat receiver: random stalls, long hold-off on request
   initial begin
      int unsigned holds_done;
      holds_done = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != holds_done) begin
            holds_done++;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // one request beat, with random idle cycles ahead of it
   task automatic push_item(input logic op, input logic [COORD_W-1:0] u,
                            input logic [COORD_W-1:0] v, input logic [WADDR_W-1:0] addr,
                            input logic [BYTE_W-1:0] data);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.coord_u    <= u;
      req_bus.coord_v    <= v;
      req_bus.write_addr <= addr;
      req_bus.write_byte <= data;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic push_write(input logic [WADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
      texel_written[addr] = 1'b1;
      push_item(OP_WRITE, COORD_W'($urandom), COORD_W'($urandom), addr, data);
   endtask

   // load any unwritten byte of the target texel before sampling it
   task automatic push_sample(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
      int unsigned base;
      int unsigned a;
      base = chk.texel_base(cfg, u, v);
      for (int k = 0; k < NUM_CHAN; k++) begin
         a = (base + k) % STORE_BYTES;
         if (!texel_written[a]) begin
            push_write(a[WADDR_W-1:0], BYTE_W'($urandom));
         end
      end
      push_item(OP_SAMPLE, u, v, WADDR_W'($urandom), BYTE_W'($urandom));
   endtask

   // coordinates biased toward whole numbers, small magnitudes and the range ends
   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(9))
         0: return {8'($urandom), 16'h0000};
         1: return {($urandom_range(1) == 1) ? 8'hFF : 8'h00, 16'($urandom)};
         2: begin
            case ($urandom_range(3))
               0: return 24'h800000;
               1: return 24'h7FFFFF;
               2: return 24'h000000;
               default: return 24'h010000;
            endcase
         end
         default: return COORD_W'($urandom);
      endcase
   endfunction

   task automatic random_item();
      if ($urandom_range(4) == 0) begin
         push_write(WADDR_W'($urandom), BYTE_W'($urandom));
      end else begin
         push_sample(pick_coord(), pick_coord());
      end
   endtask

   // stop offering, wait out every colour beat and the write tail
   task automatic wait_for_quiet();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (chk_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all registers, plus the unused indexes, with junk in the spare bits
   task automatic program_regs(input csr_type next);
      logic [CSR_DATA_W-1:0] raw;
      for (int k = 0; k < 8; k++) begin
         raw = CSR_DATA_W'($urandom);
         case (k)
            CSR_TEX_WIDTH:     raw[CFG_SIDE_W-1:0] = next.tex_width;
            CSR_TEX_HEIGHT:    raw[CFG_SIDE_W-1:0] = next.tex_height;
            CSR_CHANNEL_COUNT: raw[CFG_CH_W-1:0]   = next.channel_count;
            CSR_REPEAT_U:      raw                 = next.repeat_u;
            CSR_REPEAT_V:      raw                 = next.repeat_v;
            CSR_GAIN:          raw                 = next.gain;
            default: ;
         endcase
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(k);
         csr_wdata <= raw;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg = next;
   endtask

   // main sequence
   initial begin
      csr_type     plan [PHASES];
      int unsigned phase_end;

      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= OP_SAMPLE;
      req_bus.coord_u    <= '0;
      req_bus.coord_v    <= '0;
      req_bus.write_addr <= '0;
      req_bus.write_byte <= '0;
      cfg = CSR_RESET;

      // smallest sides, full sides with gain off, oversized and zero sides, odd strides
      plan[0] = CSR_RESET;
      plan[1] = '{11'd1, 11'd1, 3'd3, 16'd256, 16'd256, 16'hFFFF};
      plan[2] = '{11'd1024, 11'd1024, 3'd4, 16'hFFFF, 16'hFFFF, 16'd0};
      plan[3] = '{11'd2047, 11'd0, 3'd7, 16'd1, 16'd0, 16'd12345};
      plan[4] = '{11'd0, 11'd2047, 3'd0, 16'd0, 16'hFFFF, 16'd4096};
      plan[5] = '{11'($urandom_range(1, 64)), 11'($urandom_range(1, 64)),
                  3'($urandom_range(3, 4)), 16'($urandom), 16'($urandom), 16'($urandom)};
      plan[6] = '{11'd1024, 11'd1, 3'd4, 16'd512, 16'd384, 16'd40000};
      plan[7] = '{11'($urandom), 11'($urandom), 3'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom)};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: store ends, texel zero, coordinate extremes and whole numbers
      push_write(18'h00000, 8'h00);
      push_write(18'h00001, 8'hFF);
      push_write(18'h00002, 8'h80);
      push_write(18'h3FFFF, 8'hFF);
      push_sample(24'h000000, 24'h00FFFF);
      push_sample(24'h000000, 24'h000000);
      push_sample(24'h7FFFFF, 24'h800000);
      push_sample(24'h010000, 24'h010000);
      push_sample(24'hFF0000, 24'h000001);
      push_sample(24'h00FFFF, 24'h7F0000);

      // random phases, one register setting and one idling pattern each
      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            wait_for_quiet();
            program_regs(plan[p]);
         end
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 75;
               rsp_stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct <= 75;
            end
            default: begin
               send_idle_pct = 32;
               rsp_stall_pct <= 32;
            end
         endcase
         // back-pressure the whole pipeline while the sender keeps going
         if (p == HOLD_PHASE) begin
            hold_asks <= hold_asks + 1;
         end
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) begin
            random_item();
         end
      end

      rsp_stall_pct <= 0;
      wait_for_quiet();

      if (chk_mismatches == 0 && chk_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
